// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes for the sorted-array priority queue.
package spq_pkg;

  localparam int PRIO_W     = 16;
  localparam int MAX_ITEM_W = 48;
  localparam int OUT_ITEM_W = 32;

  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic  enq;
    logic  deq;
    prio_t prio;
  } cmd_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module spq_cell #(
  parameter int ITEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spq_pkg::cmd_t         cmd,
  input  logic [ITEM_WIDTH-1:0] new_item,
  input  logic                  left_gt,
  input  logic                  left_valid,
  input  spq_pkg::prio_t        left_prio,
  input  logic [ITEM_WIDTH-1:0] left_item,
  input  logic                  right_valid,
  input  spq_pkg::prio_t        right_prio,
  input  logic [ITEM_WIDTH-1:0] right_item,
  output logic                  valid,
  output spq_pkg::prio_t        prio,
  output logic [ITEM_WIDTH-1:0] item,
  output logic                  gt
);
  import spq_pkg::*;

  logic                  valid_r, valid_nxt;
  prio_t                 prio_r, prio_nxt;
  logic [ITEM_WIDTH-1:0] item_r, item_nxt;

  assign gt = valid_r && ($signed(prio_r) > $signed(cmd.prio));

  // Cell 0 is the top of the queue. On an enqueue, cells holding a strictly
  // greater priority stay, the first other cell takes the new entry and the
  // rest move one place down. On a dequeue everything moves one place up.
  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    item_nxt  = item_r;
    if (cmd.enq) begin
      if (!gt) begin
        if (left_gt) begin
          valid_nxt = 1'b1;
          prio_nxt  = cmd.prio;
          item_nxt  = new_item;
        end else begin
          valid_nxt = left_valid;
          prio_nxt  = left_prio;
          item_nxt  = left_item;
        end
      end
    end else if (cmd.deq) begin
      valid_nxt = right_valid;
      prio_nxt  = right_prio;
      item_nxt  = right_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    item_r <= item_nxt;
  end

  assign valid = valid_r;
  assign prio  = prio_r;
  assign item  = item_r;

endmodule

// ===== rtl/core/sorted_array_priority_queue_top.sv =====
// Top level of the sorted-array priority queue built as a chain of cells.
//
// Input beats carry one request: in_tuser is the operation (enqueue or
// dequeue), in_tdata the item and its signed priority. Each request gives
// exactly one output beat with a status (enqueued, dequeued, full, empty)
// and, on a dequeue, the removed item and priority.
// Entries sit in a row of CAPACITY cells sorted by priority, cell 0 holding
// the next entry to leave. Every cell compares the incoming priority in the
// same cycle and shifts toward its neighbor; a request's result appears in
// the cycle after the input beat. Throughput is one request per cycle while
// results are taken; the chain's compare-and-shift step sets that figure.
// The result waits in an output register; in_tready stays high while that
// register is empty or being taken, so a stalled receiver holds off input
// after one pending result.
// Reset empties the queue at once (cell valid bits clear); no clearing pass.
module sorted_array_priority_queue_top #(
  parameter int CAPACITY   = 128,
  parameter int ITEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] item_value, [47:32] priority_req
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] out_item, [47:32] out_priority
  output logic [1:0]  out_tuser   // [1:0] status
);
  import spq_pkg::*;

  logic                  in_fire;
  op_t                   req_op;
  prio_t                 req_prio;
  logic [MAX_ITEM_W-1:0] req_item_wide;
  logic [ITEM_WIDTH-1:0] req_item;
  cmd_t                  cmd;

  logic [CAPACITY-1:0]   cell_valid;
  logic [CAPACITY-1:0]   cell_gt;
  prio_t                 cell_prio [CAPACITY];
  logic [ITEM_WIDTH-1:0] cell_item [CAPACITY];

  logic                  q_full, q_empty;
  logic [MAX_ITEM_W-1:0] top_item_wide;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [OUT_ITEM_W-1:0] out_item_r, out_item_nxt;
  prio_t                 out_prio_r, out_prio_nxt;

  assign in_tready     = !out_valid_r || out_tready;
  assign in_fire       = in_tvalid && in_tready;
  assign req_op        = op_t'(in_tuser);
  assign req_prio      = in_tdata[47:32];
  assign req_item_wide = MAX_ITEM_W'(in_tdata[31:0]);
  assign req_item      = req_item_wide[ITEM_WIDTH-1:0];

  assign q_full  = cell_valid[CAPACITY-1];
  assign q_empty = !cell_valid[0];

  assign cmd.enq  = in_fire && (req_op == OP_ENQ) && !q_full;
  assign cmd.deq  = in_fire && (req_op == OP_DEQ) && !q_empty;
  assign cmd.prio = req_prio;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                  l_gt, l_valid, r_valid;
    prio_t                 l_prio, r_prio;
    logic [ITEM_WIDTH-1:0] l_item, r_item;

    if (k == 0) begin : g_head
      assign l_gt    = 1'b1;
      assign l_valid = 1'b0;
      assign l_prio  = '0;
      assign l_item  = '0;
    end else begin : g_link_l
      assign l_gt    = cell_gt[k-1];
      assign l_valid = cell_valid[k-1];
      assign l_prio  = cell_prio[k-1];
      assign l_item  = cell_item[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_item  = '0;
    end else begin : g_link_r
      assign r_valid = cell_valid[k+1];
      assign r_prio  = cell_prio[k+1];
      assign r_item  = cell_item[k+1];
    end

    spq_cell #(
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_item    (req_item),
      .left_gt     (l_gt),
      .left_valid  (l_valid),
      .left_prio   (l_prio),
      .left_item   (l_item),
      .right_valid (r_valid),
      .right_prio  (r_prio),
      .right_item  (r_item),
      .valid       (cell_valid[k]),
      .prio        (cell_prio[k]),
      .item        (cell_item[k]),
      .gt          (cell_gt[k])
    );
  end

  assign top_item_wide = MAX_ITEM_W'(cell_item[0]);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_prio_nxt   = out_prio_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '0;
      out_prio_nxt  = '0;
      if (req_op == OP_ENQ) begin
        out_status_nxt = q_full ? ST_FULL : ST_ENQUEUED;
      end else if (q_empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        out_status_nxt = ST_DEQUEUED;
        out_item_nxt   = top_item_wide[OUT_ITEM_W-1:0];
        out_prio_nxt   = cell_prio[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_prio_r, out_item_r};
  assign out_tuser  = out_status_r;

  // Occupied cells always form an unbroken run starting at cell 0.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (((cell_valid >> 1) & ~cell_valid) == '0))
    else $error("cell valid bits are not a contiguous prefix");

  // The two cells nearest the top stay in descending priority order.
  a_top_order: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[1] |-> ($signed(cell_prio[0]) >= $signed(cell_prio[1])))
    else $error("top cells out of priority order");

  // An enqueue into a full queue is refused in the next result beat.
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (req_op == OP_ENQ) && q_full)
      |=> (out_tvalid && (out_tuser == ST_FULL) && q_full))
    else $error("enqueue into full queue not refused");

  // A dequeue of a non-empty queue reports the entry that was at the top.
  a_deq_top: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (req_op == OP_DEQ) && !q_empty)
      |=> ((out_tuser == ST_DEQUEUED) && (out_tdata[47:32] == $past(cell_prio[0]))))
    else $error("dequeue did not return the top entry");

endmodule

// ===== dv/sorted_array_priority_queue_top_tb.sv =====
// Self-checking testbench for the sorted-array priority queue top level.
module sorted_array_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int CAPACITY       = 128;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int SEGMENT_LEN    = 280;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum int {
    SEG_FILL,
    SEG_DRAIN,
    SEG_MIXED
  } segment_t;

  typedef struct {
    op_t         op;
    logic [31:0] item;
    prio_t       prio;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] item;
    prio_t       prio;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [31:0] item_value, [47:32] priority_req
  logic        in_tuser = 1'b0; // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [31:0] out_item, [47:32] out_priority
  logic [1:0]  out_tuser;       // [1:0] status

  request_t pending_requests[$];
  result_t  expected_results[$];
  request_t on_bus;
  int       beats_sent = 0;
  int       mismatches = 0;
  logic     hold_rx = 1'b0;

  // Shadow copy of the queue, ascending by priority; the top sits at the end.
  logic [31:0] held_item[CAPACITY];
  prio_t       held_prio[CAPACITY];
  int          held_count = 0;

  sorted_array_priority_queue_top #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t apply_request(request_t req);
    result_t res;
    int      pos;
    res.status = ST_ENQUEUED;
    res.item   = '0;
    res.prio   = '0;
    if (req.op == OP_ENQ) begin
      if (held_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = held_count;
        for (int i = 0; i < held_count; i++) begin
          if (held_prio[i] > req.prio) begin
            pos = i;
            break;
          end
        end
        for (int i = held_count; i > pos; i--) begin
          held_item[i] = held_item[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_item[pos] = req.item;
        held_prio[pos] = req.prio;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      held_count--;
      res.status = ST_DEQUEUED;
      res.item   = held_item[held_count];
      res.prio   = held_prio[held_count];
    end
    return res;
  endfunction

  // Phases rotate with the number of input beats, so every kind of gap lands
  // on fills, drains and the full and empty corners.
  function automatic idle_mode_t idle_mode();
    case ((beats_sent / 97) % 5)
      1: return IDLE_SENDER;
      2: return IDLE_RECEIVER;
      3: return IDLE_BOTH;
      default: return IDLE_NONE;
    endcase
  endfunction

  function automatic bit gap_roll(idle_mode_t mode, idle_mode_t side);
    if (mode == IDLE_BOTH) return $urandom_range(99) < 31;
    if (mode == side) return $urandom_range(99) < 87;
    return 1'b0;
  endfunction

  // Ties are frequent on purpose so the newest-first rule gets exercised.
  function automatic prio_t random_prio();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return prio_t'(16'sh8000);
      1: return prio_t'(16'sh7fff);
      2, 3, 4: return prio_t'($urandom_range(6) - 3);
      default: return prio_t'($urandom);
    endcase
  endfunction

  task automatic add_request(op_t op, logic [31:0] item, prio_t prio);
    request_t req;
    req.op   = op;
    req.item = item;
    req.prio = prio;
    pending_requests.push_back(req);
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endtask

  // Driver: predicts on every accepted beat, then offers the next request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(on_bus));
        beats_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && !gap_roll(idle_mode(), IDLE_SENDER)) begin
          on_bus = pending_requests.pop_front();
          in_tdata  <= {on_bus.prio, on_bus.item};
          in_tuser  <= on_bus.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat status %0d item %h prio %0d",
                                    out_tuser, out_tdata[31:0], $signed(out_tdata[47:32])));
        end else begin
          want = expected_results.pop_front();
          if (out_tuser != want.status || out_tdata[31:0] != want.item ||
              out_tdata[47:32] != want.prio) begin
            report_mismatch($sformatf(
              "expected status %s item %h prio %0d, got status %0d item %h prio %0d",
              want.status.name(), want.item, want.prio,
              out_tuser, out_tdata[31:0], $signed(out_tdata[47:32])));
          end
        end
      end
      out_tready <= !hold_rx && !gap_roll(idle_mode(), IDLE_RECEIVER);
    end
  end

  // Long receiver hold-off early in the first fill while the sender keeps
  // going, so the block backs up and drops in_tready.
  initial begin
    while (beats_sent < 40) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int       total;
    int       seg;
    int       enq_pct;
    segment_t kind;

    // Directed: empty dequeue, field extremes, ties at zero and at the top
    // priority, then drain everything and hit empty again.
    add_request(OP_DEQ, 32'h0, prio_t'(0));
    add_request(OP_ENQ, 32'h0000_0000, prio_t'(16'sh8000));
    add_request(OP_ENQ, 32'hffff_ffff, prio_t'(16'sh7fff));
    add_request(OP_ENQ, 32'ha5a5_a5a5, prio_t'(0));
    add_request(OP_ENQ, 32'h5a5a_5a5a, prio_t'(0));
    add_request(OP_ENQ, 32'h1234_5678, prio_t'(-1));
    add_request(OP_ENQ, 32'h8765_4321, prio_t'(16'sh7fff));
    add_request(OP_ENQ, 32'hdead_beef, prio_t'(16'sh8000));
    add_request(OP_DEQ, 32'hffff_ffff, prio_t'(16'sh7fff));
    add_request(OP_ENQ, 32'h0000_0001, prio_t'(1));
    repeat (8) add_request(OP_DEQ, $urandom, prio_t'($urandom));
    add_request(OP_DEQ, 32'h0, prio_t'(0));

    // Random: fill runs reach the full corner, drain runs reach empty.
    total = 0;
    seg   = 0;
    while (total < RANDOM_ITEMS) begin
      kind = segment_t'(seg % 3);
      enq_pct = (kind == SEG_FILL) ? 92 : (kind == SEG_DRAIN) ? 8 : 50;
      repeat (SEGMENT_LEN) begin
        add_request(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ,
                    $urandom, random_prio());
      end
      total += SEGMENT_LEN;
      seg++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
